/* hw/rtl/sssn_pkg.sv */
package sssn_pkg;

    localparam int STRIP_SIZE_DEF      = 192;
    localparam int EDGE_HALF_WIDTH_DEF = 1;

    localparam logic [14:0] EDGE_RESET = 15'd12288;
    localparam logic [14:0] FULL_RESET = 15'd9830;
    localparam logic [15:0] ONE_Q14    = 16'd16384;

    // bias = 4096 * 245760, keeps the numerator positive for the divider
    localparam logic signed [33:0] NUM_BIAS = 34'sd1006632960;
    // floor(n / 15) = (n * RECIP15) >> 35 for any 32-bit n
    localparam logic [31:0]        RECIP15  = 32'h88888889;

    localparam logic REG_EDGE = 1'b0;
    localparam logic REG_FULL = 1'b1;

    typedef enum logic [1:0] {
        FUNC_CLEAR = 2'd0,
        FUNC_SPLAT = 2'd1,
        FUNC_MIN   = 2'd2,
        FUNC_READ  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        OFF_M1 = 2'd0,
        OFF_Z  = 2'd1,
        OFF_P1 = 2'd2
    } off_t;

    typedef enum logic [2:0] {
        C_EN1  = 3'd0,
        C_EZ   = 3'd1,
        C_EP1  = 3'd2,
        C_FN1  = 3'd3,
        C_FNZ  = 3'd4,
        C_FULL = 3'd5,
        C_FZP  = 3'd6,
        C_FP1  = 3'd7
    } coef_sel_t;

    typedef enum logic [1:0] {
        A_SPLAT = 2'd0,
        A_CNT   = 2'd1,
        A_IDX   = 2'd2
    } addr_sel_t;

    typedef struct packed {
        logic      latch_in;
        logic      prep;
        logic      div_step;
        logic      coef1;
        logic      coef2;
        logic      bounds;
        logic      i_clr;
        logic      i_lo;
        logic      i_inc;
        logic      mem_rd;
        addr_sel_t addr_sel;
        off_t      off;
        coef_sel_t coef;
        logic      mul_en;
        logic      mem_wr;
        logic      wr_fill;
        logic      min_cmp;
        logic      min_store;
        logic      out_load;
    } cmd_t;

    typedef struct packed {
        func_t func;
        logic  idx_ok;
        logic  i_lt_lr;
        logic  i1_lt_rl;
        logic  i_lt_rl;
        logic  i_lt_rr;
        logic  i_end_all;
        logic  i_end_min;
        logic  out_full;
    } status_t;

    // 16384 - round((16384 - s) * w / 32768)
    function automatic logic [15:0] side_coef(input logic [14:0] s, input logic [14:0] w);
        logic signed [16:0] d;
        logic signed [32:0] p;
        logic signed [16:0] r;
        d = 17'sd16384 - $signed({2'b00, s});
        p = 33'(d) * $signed({18'b0, w}) + 33'sd16384;
        r = 17'(p >>> 15);
        return 16'(17'sd16384 - r);
    endfunction

    // 16384 - round((16384 - s) / 2)
    function automatic logic [15:0] mid_coef(input logic [14:0] s);
        logic signed [16:0] d;
        logic signed [16:0] r;
        d = 17'sd16384 - $signed({2'b00, s});
        r = (d + 17'sd1) >>> 1;
        return 16'(17'sd16384 - r);
    endfunction

    function automatic logic [15:0] q14_round(input logic [31:0] p);
        logic [32:0] v;
        v = {1'b0, p} + 33'd8192;
        if (v[32:30] != 3'b000) begin
            return 16'hFFFF;
        end
        return v[29:14];
    endfunction

endpackage

/* hw/rtl/shadow_strip_splat_normalize_core.sv */
// Cloud shadow strip: a strip of STRIP_SIZE shadow factors in Q2.14.
// Input channel (s_valid/s_ready) takes one command beat: s_func selects
// clear (0), splat a cloud at s_cloud_x with s_cloud_scale (1), compute the
// min offset over the central third (2) or read element s_read_index (3).
// Only a read of an index inside the strip returns a result beat on the
// m_ channel (m_shadow_value, m_value_index); other commands return none.
// Commands run one at a time on a single-port strip memory:
//   clear: one element written per cycle across the whole strip.
//   splat: setup (prep, reciprocal multiply by 1/15 for the left edge,
//          coefficients, bounds), then per position a plan step and per tap
//          a read, multiply and write; 3 taps per edge position, 1 per middle.
//   min:   a read and a compare per element, STRIP_SIZE/3 elements.
//   read:  the element is read, then loaded into the output register once free.
// After reset the strip is filled with 1.0 by a clearing pass, during which
// s_ready stays low; APB writes are taken at any time.
// A result beat waits in an output register; a stalled receiver holds the
// block only when the next read result is due.
module shadow_strip_splat_normalize_core #(
    parameter int STRIP_SIZE      = sssn_pkg::STRIP_SIZE_DEF,
    parameter int EDGE_HALF_WIDTH = sssn_pkg::EDGE_HALF_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [15:0] s_cloud_x,
    input  logic [15:0]        s_cloud_scale,
    input  logic [7:0]         s_read_index,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_shadow_value,
    output logic [7:0]         m_value_index
);

    sssn_pkg::cmd_t    cmd;
    sssn_pkg::status_t st;
    logic [14:0]       edge_f;
    logic [14:0]       full_f;

    sssn_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .edge_f  (edge_f),
        .full_f  (full_f)
    );

    sssn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_ready (m_ready),
        .st      (st),
        .cmd     (cmd)
    );

    sssn_dp #(
        .STRIP_SIZE      (STRIP_SIZE),
        .EDGE_HALF_WIDTH (EDGE_HALF_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .st             (st),
        .s_func         (s_func),
        .s_cloud_x      (s_cloud_x),
        .s_cloud_scale  (s_cloud_scale),
        .s_read_index   (s_read_index),
        .edge_f         (edge_f),
        .full_f         (full_f),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_shadow_value (m_shadow_value),
        .m_value_index  (m_value_index)
    );

endmodule

/* hw/rtl/sssn_regs.sv */
module sssn_regs (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [14:0] edge_f,
    output logic [14:0] full_f
);

    localparam logic REG_EDGE_SEL = sssn_pkg::REG_EDGE;

    logic [14:0] edge_reg, edge_next;
    logic [14:0] full_reg, full_next;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb begin
        edge_next = edge_reg;
        full_next = full_reg;
        if (wr_en) begin
            unique case (paddr[2])
                REG_EDGE_SEL: edge_next = pwdata[14:0];
                default:      full_next = pwdata[14:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_reg <= sssn_pkg::EDGE_RESET;
            full_reg <= sssn_pkg::FULL_RESET;
        end else begin
            edge_reg <= edge_next;
            full_reg <= full_next;
        end
    end

    always_comb begin
        if (paddr[2] == sssn_pkg::REG_FULL) begin
            prdata = {17'b0, full_reg};
        end else begin
            prdata = {17'b0, edge_reg};
        end
    end

    assign edge_f = edge_reg;
    assign full_f = full_reg;

endmodule

/* hw/rtl/sssn_dp.sv */
module sssn_dp #(
    parameter int STRIP_SIZE      = sssn_pkg::STRIP_SIZE_DEF,
    parameter int EDGE_HALF_WIDTH = sssn_pkg::EDGE_HALF_WIDTH_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  sssn_pkg::cmd_t    cmd,
    output sssn_pkg::status_t st,
    input  logic [1:0]        s_func,
    input  logic signed [15:0] s_cloud_x,
    input  logic [15:0]       s_cloud_scale,
    input  logic [7:0]        s_read_index,
    input  logic [14:0]       edge_f,
    input  logic [14:0]       full_f,
    input  logic              m_ready,
    output logic              m_valid,
    output logic [14:0]       m_shadow_value,
    output logic [7:0]        m_value_index
);

    localparam int IW    = $clog2(STRIP_SIZE);
    localparam int SW    = $clog2(STRIP_SIZE + 1);
    localparam int NUM_W = 23 + SW;
    localparam int CP_W  = 16 + SW;
    localparam int CQ_W  = CP_W + 3;
    localparam int CNT_W = $clog2((65535 * STRIP_SIZE) / 40960 + 1);
    localparam int LW    = 20;
    localparam int HI    = (STRIP_SIZE * 2) / 3;
    localparam int LO    = STRIP_SIZE / 3;

    localparam logic signed [NUM_W-1:0] SIZE_N = NUM_W'(STRIP_SIZE);
    localparam logic signed [LW-1:0]    TOP_S  = LW'(STRIP_SIZE - 2);
    localparam logic signed [LW-1:0]    HW_S   = LW'(EDGE_HALF_WIDTH);
    localparam logic signed [LW-1:0]    LBIAS  = LW'(4096);
    localparam logic signed [LW-1:0]    ONE_S  = LW'(1);
    localparam logic signed [LW-1:0]    ZERO_S = LW'(0);

    function automatic logic [IW-1:0] clampi(input logic signed [LW-1:0] v,
                                             input logic signed [LW-1:0] lo);
        logic signed [LW-1:0] t;
        t = v;
        if (t < lo) begin
            t = lo;
        end
        if (t > TOP_S) begin
            t = TOP_S;
        end
        return t[IW-1:0];
    endfunction

    logic [1:0]        func_reg;
    logic signed [15:0] x_reg;
    logic [15:0]       scale_reg;
    logic [7:0]        idx_reg;
    logic [31:0]       nb_reg;
    logic [CP_W-1:0]   cprod_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [15:0]       en1_reg, ez_reg, ep1_reg, fn1_reg, fz_reg, fp1_reg;
    logic [15:0]       fnz_reg, fzp_reg;
    logic [IW-1:0]     lr_reg, rl_reg, rr_reg;
    logic [IW-1:0]     i_reg;
    logic [15:0]       rd_reg;
    logic [31:0]       prod_reg;
    logic [15:0]       min_reg;
    logic [14:0]       off_reg;
    logic [14:0]       oval_reg;
    logic [7:0]        oidx_reg;
    logic              ofull_reg;
    logic [15:0]       mem [STRIP_SIZE];

    logic signed [21:0]   s20;
    logic signed [NUM_W-1:0] num;
    logic signed [33:0]   nbs;
    logic [63:0]          qprod;
    logic [13:0]          frac;
    logic [14:0]          nfrac;
    logic [CQ_W-1:0]      cq;
    logic signed [LW-1:0] lft, cnt_s;
    logic [IW-1:0]        addr;
    logic [IW:0]          i_ext;
    logic [15:0]          coef;
    logic [15:0]          wdata;
    logic [15:0]          mn;
    logic [16:0]          osum;

    // numerator of the left edge index, biased positive
    assign s20 = $signed({{6{x_reg[15]}}, x_reg}) * 22'sd20 + 22'sd122880
               - $signed({6'b0, scale_reg}) * 22'sd3;
    assign num = NUM_W'(s20) * SIZE_N;
    assign nbs = 34'(num) + sssn_pkg::NUM_BIAS;

    // divide by 15 through the reciprocal; low 14 bits of the quotient are the fraction
    assign qprod = 64'(nb_reg) * 64'(sssn_pkg::RECIP15);

    assign frac  = nb_reg[13:0];
    assign nfrac = 15'd16384 - {1'b0, frac};
    assign cq    = CQ_W'(cprod_reg[CP_W-1:13]) * CQ_W'(52429);

    assign lft   = $signed({2'b00, nb_reg[31:14]}) - LBIAS;
    assign cnt_s = $signed(LW'(cnt_reg));

    assign i_ext = {1'b0, i_reg};

    always_comb begin
        unique case (cmd.addr_sel)
            sssn_pkg::A_SPLAT: begin
                unique case (cmd.off)
                    sssn_pkg::OFF_M1: addr = IW'(i_ext - 1'b1);
                    sssn_pkg::OFF_P1: addr = IW'(i_ext + 1'b1);
                    default:          addr = i_reg;
                endcase
            end
            sssn_pkg::A_IDX: addr = IW'(idx_reg);
            default:         addr = i_reg;
        endcase
    end

    always_comb begin
        unique case (cmd.coef)
            sssn_pkg::C_EN1:  coef = en1_reg;
            sssn_pkg::C_EZ:   coef = ez_reg;
            sssn_pkg::C_EP1:  coef = ep1_reg;
            sssn_pkg::C_FN1:  coef = fn1_reg;
            sssn_pkg::C_FNZ:  coef = fnz_reg;
            sssn_pkg::C_FULL: coef = {1'b0, full_f};
            sssn_pkg::C_FZP:  coef = fzp_reg;
            default:          coef = fp1_reg;
        endcase
    end

    assign wdata = cmd.wr_fill ? sssn_pkg::ONE_Q14 : sssn_pkg::q14_round(prod_reg);
    assign mn    = (rd_reg < min_reg) ? rd_reg : min_reg;
    assign osum  = {1'b0, rd_reg} + {2'b00, off_reg};

    always_ff @(posedge aclk) begin
        if (cmd.mem_wr) begin
            mem[addr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rd_reg <= mem[addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            func_reg  <= s_func;
            x_reg     <= s_cloud_x;
            scale_reg <= s_cloud_scale;
            idx_reg   <= s_read_index;
        end
        if (cmd.prep) begin
            nb_reg    <= nbs[31:0];
            cprod_reg <= CP_W'(scale_reg) * CP_W'(STRIP_SIZE);
        end else if (cmd.div_step) begin
            nb_reg    <= 32'(qprod >> 35);
        end
        if (cmd.coef1) begin
            en1_reg <= sssn_pkg::side_coef(edge_f, nfrac);
            ez_reg  <= sssn_pkg::mid_coef(edge_f);
            ep1_reg <= sssn_pkg::side_coef(edge_f, {1'b0, frac});
            fn1_reg <= sssn_pkg::side_coef(full_f, nfrac);
            fz_reg  <= sssn_pkg::mid_coef(full_f);
            fp1_reg <= sssn_pkg::side_coef(full_f, {1'b0, frac});
            cnt_reg <= CNT_W'(cq >> 18);
        end
        if (cmd.coef2) begin
            fnz_reg <= sssn_pkg::q14_round(32'(fn1_reg) * 32'(fz_reg));
            fzp_reg <= sssn_pkg::q14_round(32'(fz_reg) * 32'(fp1_reg));
        end
        if (cmd.bounds) begin
            lr_reg <= clampi(lft + HW_S, ZERO_S);
            rl_reg <= clampi(lft + cnt_s - HW_S, ZERO_S);
            rr_reg <= clampi(lft + cnt_s + HW_S, ZERO_S);
        end
        if (cmd.mul_en) begin
            prod_reg <= 32'(rd_reg) * 32'(coef);
        end
        if (cmd.i_lo) begin
            min_reg <= sssn_pkg::ONE_Q14;
        end else if (cmd.min_cmp) begin
            min_reg <= mn;
        end
        if (cmd.out_load) begin
            oval_reg <= (osum > 17'd32767) ? 15'h7FFF : osum[14:0];
            oidx_reg <= idx_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_reg     <= '0;
            off_reg   <= '0;
            ofull_reg <= 1'b0;
        end else begin
            if (cmd.i_clr) begin
                i_reg <= '0;
            end else if (cmd.i_lo) begin
                i_reg <= IW'(LO);
            end else if (cmd.bounds) begin
                i_reg <= clampi(lft - HW_S, ONE_S);
            end else if (cmd.i_inc) begin
                i_reg <= IW'(i_ext + 1'b1);
            end
            if (cmd.min_store) begin
                off_reg <= 15'(17'd16384 - {1'b0, mn});
            end
            if (cmd.out_load) begin
                ofull_reg <= 1'b1;
            end else if (m_ready) begin
                ofull_reg <= 1'b0;
            end
        end
    end

    assign st.func      = sssn_pkg::func_t'(func_reg);
    assign st.idx_ok    = 32'(idx_reg) < STRIP_SIZE;
    assign st.i_lt_lr   = i_reg < lr_reg;
    assign st.i1_lt_rl  = (i_ext + 1'b1) < {1'b0, rl_reg};
    assign st.i_lt_rl   = i_reg < rl_reg;
    assign st.i_lt_rr   = i_reg < rr_reg;
    assign st.i_end_all = i_reg == IW'(STRIP_SIZE - 1);
    assign st.i_end_min = i_reg == IW'(HI - 1);
    assign st.out_full  = ofull_reg;

    assign m_valid        = ofull_reg;
    assign m_shadow_value = oval_reg;
    assign m_value_index  = oidx_reg;

`ifndef NO_ASSERTIONS
    a_addr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.mem_wr || cmd.mem_rd) |-> (32'(addr) < STRIP_SIZE))
        else $error("strip access out of range");
    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.min_store |=> (off_reg <= 15'd16384))
        else $error("min offset above one");
`endif

endmodule

/* hw/rtl/sssn_ctrl.sv */
module sssn_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              m_ready,
    input  sssn_pkg::status_t st,
    output sssn_pkg::cmd_t    cmd
);

    typedef enum logic [15:0] {
        S_CLEAR = 16'h0001,
        S_IDLE  = 16'h0002,
        S_DISP  = 16'h0004,
        S_DIV   = 16'h0008,
        S_COEF1 = 16'h0010,
        S_COEF2 = 16'h0020,
        S_BOUND = 16'h0040,
        S_PLAN  = 16'h0080,
        S_RD    = 16'h0100,
        S_MUL   = 16'h0200,
        S_WR    = 16'h0400,
        S_MRD   = 16'h0800,
        S_MCMP  = 16'h1000,
        S_RRD   = 16'h2000,
        S_ROUT  = 16'h4000
    } state_t;

    typedef enum logic [2:0] {
        PH_A = 3'd0,
        PH_B = 3'd1,
        PH_C = 3'd2,
        PH_D = 3'd3,
        PH_E = 3'd4
    } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] k_reg, k_next;
    logic [1:0] k_last;
    logic       run;

    // tap order of each group of the splat walk
    always_comb begin
        cmd.off  = sssn_pkg::OFF_Z;
        cmd.coef = sssn_pkg::C_FULL;
        k_last   = 2'd0;
        unique case (phase_reg)
            PH_B: begin
                k_last   = 2'd1;
                cmd.off  = (k_reg == 2'd0) ? sssn_pkg::OFF_M1 : sssn_pkg::OFF_Z;
                cmd.coef = (k_reg == 2'd0) ? sssn_pkg::C_FN1 : sssn_pkg::C_FNZ;
            end
            PH_C: begin
                k_last   = 2'd0;
            end
            PH_D: begin
                k_last   = 2'd1;
                cmd.off  = (k_reg == 2'd0) ? sssn_pkg::OFF_Z : sssn_pkg::OFF_P1;
                cmd.coef = (k_reg == 2'd0) ? sssn_pkg::C_FZP : sssn_pkg::C_FP1;
            end
            default: begin
                k_last = 2'd2;
                priority case (k_reg)
                    2'd0: begin
                        cmd.off  = sssn_pkg::OFF_M1;
                        cmd.coef = sssn_pkg::C_EN1;
                    end
                    2'd1: begin
                        cmd.off  = sssn_pkg::OFF_Z;
                        cmd.coef = sssn_pkg::C_EZ;
                    end
                    default: begin
                        cmd.off  = sssn_pkg::OFF_P1;
                        cmd.coef = sssn_pkg::C_EP1;
                    end
                endcase
            end
        endcase
    end

    always_comb begin
        unique case (phase_reg)
            PH_A:    run = st.i_lt_lr;
            PH_B:    run = st.i1_lt_rl;
            PH_C:    run = st.i1_lt_rl;
            PH_D:    run = st.i_lt_rl;
            default: run = st.i_lt_rr;
        endcase
    end

    assign s_ready = state_reg == S_IDLE;

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        k_next        = k_reg;
        cmd.latch_in  = 1'b0;
        cmd.prep      = 1'b0;
        cmd.div_step  = 1'b0;
        cmd.coef1     = 1'b0;
        cmd.coef2     = 1'b0;
        cmd.bounds    = 1'b0;
        cmd.i_clr     = 1'b0;
        cmd.i_lo      = 1'b0;
        cmd.i_inc     = 1'b0;
        cmd.mem_rd    = 1'b0;
        cmd.addr_sel  = sssn_pkg::A_CNT;
        cmd.mul_en    = 1'b0;
        cmd.mem_wr    = 1'b0;
        cmd.wr_fill   = 1'b0;
        cmd.min_cmp   = 1'b0;
        cmd.min_store = 1'b0;
        cmd.out_load  = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.mem_wr  = 1'b1;
                cmd.wr_fill = 1'b1;
                if (st.i_end_all) begin
                    state_next = S_IDLE;
                end else begin
                    cmd.i_inc = 1'b1;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DISP;
                end
            end
            S_DISP: begin
                unique case (st.func)
                    sssn_pkg::FUNC_CLEAR: begin
                        cmd.i_clr  = 1'b1;
                        state_next = S_CLEAR;
                    end
                    sssn_pkg::FUNC_SPLAT: begin
                        cmd.prep   = 1'b1;
                        state_next = S_DIV;
                    end
                    sssn_pkg::FUNC_MIN: begin
                        cmd.i_lo   = 1'b1;
                        state_next = S_MRD;
                    end
                    default: begin
                        state_next = st.idx_ok ? S_RRD : S_IDLE;
                    end
                endcase
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                state_next   = S_COEF1;
            end
            S_COEF1: begin
                cmd.coef1  = 1'b1;
                state_next = S_COEF2;
            end
            S_COEF2: begin
                cmd.coef2  = 1'b1;
                state_next = S_BOUND;
            end
            S_BOUND: begin
                cmd.bounds = 1'b1;
                phase_next = PH_A;
                state_next = S_PLAN;
            end
            S_PLAN: begin
                if (run) begin
                    k_next     = 2'd0;
                    state_next = S_RD;
                end else begin
                    unique case (phase_reg)
                        PH_A:    phase_next = PH_B;
                        PH_B:    phase_next = PH_C;
                        PH_C:    phase_next = PH_D;
                        PH_D:    phase_next = PH_E;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_RD: begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = sssn_pkg::A_SPLAT;
                state_next   = S_MUL;
            end
            S_MUL: begin
                cmd.mul_en = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                cmd.mem_wr   = 1'b1;
                cmd.addr_sel = sssn_pkg::A_SPLAT;
                if (k_reg == k_last) begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_PLAN;
                    unique case (phase_reg)
                        PH_B:    phase_next = PH_C;
                        PH_D:    phase_next = PH_E;
                        default: phase_next = phase_reg;
                    endcase
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_RD;
                end
            end
            S_MRD: begin
                cmd.mem_rd = 1'b1;
                state_next = S_MCMP;
            end
            S_MCMP: begin
                cmd.min_cmp = 1'b1;
                if (st.i_end_min) begin
                    cmd.min_store = 1'b1;
                    state_next    = S_IDLE;
                end else begin
                    cmd.i_inc  = 1'b1;
                    state_next = S_MRD;
                end
            end
            S_RRD: begin
                cmd.mem_rd   = 1'b1;
                cmd.addr_sel = sssn_pkg::A_IDX;
                state_next   = S_ROUT;
            end
            default: begin
                if (!st.out_full || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_A;
            k_reg     <= 2'd0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_wr_next: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WR) |=> (state_reg == S_PLAN || state_reg == S_RD))
        else $error("splat write not followed by plan or read");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!st.out_full || m_ready))
        else $error("output register overwritten");
    a_div_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |=> (state_reg == S_COEF1))
        else $error("divider did not hand over");
`endif

endmodule

/* tb/sv/shadow_strip_splat_normalize_checker.sv */
module shadow_strip_splat_normalize_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [1:0]         s_func,
    input  logic signed [15:0] s_cloud_x,
    input  logic [15:0]        s_cloud_scale,
    input  logic [7:0]         s_read_index,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [14:0]        m_shadow_value,
    input  logic [7:0]         m_value_index,
    output int                 pending,
    output int                 fail_count
);

    localparam int NSTRIP = sssn_pkg::STRIP_SIZE_DEF;
    localparam int HALF   = sssn_pkg::EDGE_HALF_WIDTH_DEF;

    typedef struct {
        logic [14:0] value;
        logic [7:0]  index;
    } shadow_read_t;

    shadow_read_t       read_q[$];
    int unsigned        strip[NSTRIP];
    int unsigned        offset_q14;
    logic [14:0]        edge_f;
    logic [14:0]        full_f;

    assign pending = read_q.size();

    function automatic longint fdiv(longint a, longint b);
        longint q;
        q = a / b;
        if ((a % b) != 0 && a < 0) q -= 1;
        return q;
    endfunction

    function automatic int unsigned qmul(int unsigned a, int unsigned c);
        longint unsigned v;
        v = (longint'(a) * longint'(c) + 8192) >> 14;
        return (v > 65535) ? 65535 : int'(v);
    endfunction

    function automatic void scale_at(longint i, int unsigned c);
        if (i >= 0 && i < NSTRIP) strip[i] = qmul(strip[i], c);
    endfunction

    function automatic void coeffs(int unsigned s, longint f,
                                   output int unsigned n1, output int unsigned z,
                                   output int unsigned p1);
        longint d;
        d = 16384 - longint'(s);
        n1 = int'(16384 - fdiv(d * (16384 - f) + 16384, 32768));
        z  = int'(16384 - fdiv(d + 1, 2));
        p1 = int'(16384 - fdiv(d * f + 16384, 32768));
    endfunction

    function automatic void splat_cloud(longint x, longint sc);
        longint top, num, left, frac, cnt, ll, lr, rl, rr, i;
        int unsigned en1, ez, ep1, fn1, fz, fp1;
        top  = NSTRIP - 2;
        num  = (20 * x + 122880 - 3 * sc) * NSTRIP;
        left = fdiv(num, 245760);
        frac = ((num - left * 245760) * 16384) / 245760;
        cnt  = (sc * NSTRIP) / 40960;
        coeffs(edge_f, frac, en1, ez, ep1);
        coeffs(full_f, frac, fn1, fz, fp1);
        ll = left - HALF;
        if (ll < 1) ll = 1;
        if (ll > top) ll = top;
        lr = (left + HALF < top) ? left + HALF : top;
        rl = (left + cnt - HALF < top) ? left + cnt - HALF : top;
        rr = (left + cnt + HALF < top) ? left + cnt + HALF : top;
        i = ll;
        for (; i < lr; i++) begin
            scale_at(i - 1, en1);
            scale_at(i, ez);
            scale_at(i + 1, ep1);
        end
        if (i < rl - 1) begin
            scale_at(i - 1, fn1);
            scale_at(i, qmul(fn1, fz));
            i++;
        end
        for (; i < rl - 1; i++) scale_at(i, full_f);
        if (i < rl) begin
            scale_at(i, qmul(fz, fp1));
            scale_at(i + 1, fp1);
            i++;
        end
        for (; i < rr; i++) begin
            scale_at(i - 1, en1);
            scale_at(i, ez);
            scale_at(i + 1, ep1);
        end
    endfunction

    function automatic void apply_command(sssn_pkg::func_t fn, logic signed [15:0] x,
                                          logic [15:0] sc, logic [7:0] idx);
        int unsigned m;
        int unsigned v;
        shadow_read_t r;
        case (fn)
            sssn_pkg::FUNC_CLEAR: begin
                foreach (strip[k]) strip[k] = 16384;
            end
            sssn_pkg::FUNC_SPLAT: splat_cloud(longint'(x), longint'(sc));
            sssn_pkg::FUNC_MIN: begin
                m = 16384;
                for (int k = NSTRIP / 3; k < NSTRIP * 2 / 3; k++)
                    if (strip[k] < m) m = strip[k];
                offset_q14 = 16384 - m;
            end
            default: begin
                if (idx < NSTRIP) begin
                    v = strip[idx] + offset_q14;
                    if (v > 32767) v = 32767;
                    r.value = v[14:0];
                    r.index = idx;
                    read_q.push_back(r);
                end
            end
        endcase
    endfunction

    initial begin
        foreach (strip[k]) strip[k] = 16384;
        offset_q14 = 0;
        edge_f = sssn_pkg::EDGE_RESET;
        full_f = sssn_pkg::FULL_RESET;
        fail_count = 0;
    end

    always @(posedge aclk) begin
        shadow_read_t e;
        if (aresetn) begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == sssn_pkg::REG_FULL) full_f = pwdata[14:0];
                else edge_f = pwdata[14:0];
            end
            if (s_valid && s_ready)
                apply_command(sssn_pkg::func_t'(s_func), s_cloud_x, s_cloud_scale,
                              s_read_index);
            if (m_valid && m_ready) begin
                if (read_q.size() == 0) begin
                    $error("result beat with nothing expected: value %0d index %0d",
                           m_shadow_value, m_value_index);
                    fail_count++;
                end else begin
                    e = read_q.pop_front();
                    if (m_shadow_value !== e.value) begin
                        $error("shadow_value expected %0d actual %0d", e.value, m_shadow_value);
                        fail_count++;
                    end
                    if (m_value_index !== e.index) begin
                        $error("value_index expected %0d actual %0d", e.index, m_value_index);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

/* tb/sv/shadow_strip_splat_normalize_core_tb.sv */
module shadow_strip_splat_normalize_core_tb;

    logic               aclk;
    logic               aresetn;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_func;
    logic signed [15:0] s_cloud_x;
    logic [15:0]        s_cloud_scale;
    logic [7:0]         s_read_index;
    logic               m_valid;
    logic               m_ready;
    logic [14:0]        m_shadow_value;
    logic [7:0]         m_value_index;
    int                 pending;
    int                 fail_count;
    int                 reads_taken;
    bit                 send_quiet;

    shadow_strip_splat_normalize_core dut (.*);

    shadow_strip_splat_normalize_checker chk (.*);

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("simulation failed");
        $finish;
    end

    // receiver: random stalls per beat, one long hold-off to back up the block
    initial begin
        int  n;
        bit  held;
        held = 0;
        reads_taken = 0;
        m_ready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            n = ((reads_taken / 40) % 3 == 0) ? 0 : $urandom_range(0, 17);
            if (!held && reads_taken == 60) begin
                n = 3000;
                held = 1;
            end
            if (n > 0) begin
                m_ready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            reads_taken++;
        end
    end

    task automatic reg_write(logic sel, logic [14:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= {17'd0, val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic send_beat(sssn_pkg::func_t fn, logic [15:0] x, logic [15:0] sc,
                             logic [7:0] idx);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_func        <= fn;
        s_cloud_x     <= x;
        s_cloud_scale <= sc;
        s_read_index  <= idx;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_beat();
        int          r;
        logic [15:0] x;
        logic [15:0] sc;
        logic [7:0]  idx;
        r   = $urandom_range(0, 99);
        x   = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
        sc  = ($urandom_range(0, 6) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        idx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(192, 255))
                                          : 8'($urandom_range(0, 191));
        if (r < 4)       send_beat(sssn_pkg::FUNC_CLEAR, x, sc, idx);
        else if (r < 40) send_beat(sssn_pkg::FUNC_SPLAT, x, sc, idx);
        else if (r < 50) send_beat(sssn_pkg::FUNC_MIN, x, sc, idx);
        else             send_beat(sssn_pkg::FUNC_READ, x, sc, idx);
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (pending != 0) @(posedge aclk);
        repeat (1500) @(posedge aclk);
    endtask

    initial begin
        logic [14:0] edge_set[6];
        logic [14:0] full_set[6];
        edge_set = '{15'd12288, 15'd0, 15'd16384, 15'd32767, 15'd0, 15'd16384};
        full_set = '{15'd9830, 15'd0, 15'd16384, 15'd32767, 15'd16384, 15'd0};
        aresetn       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_valid       <= 1'b0;
        s_func        <= sssn_pkg::FUNC_CLEAR;
        s_cloud_x     <= '0;
        s_cloud_scale <= '0;
        s_read_index  <= '0;
        send_quiet    = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: strip edges, out-of-range reads, extreme clouds
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd0);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd191);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd192);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd255);
        send_beat(sssn_pkg::FUNC_MIN, 16'd0, 16'd0, 8'd0);
        send_beat(sssn_pkg::FUNC_SPLAT, 16'd0, 16'd4096, 8'd0);
        send_beat(sssn_pkg::FUNC_SPLAT, 16'h8000, 16'd0, 8'd0);
        send_beat(sssn_pkg::FUNC_SPLAT, 16'h7FFF, 16'hFFFF, 8'd0);
        send_beat(sssn_pkg::FUNC_SPLAT, 16'h7FFF, 16'd0, 8'd0);
        send_beat(sssn_pkg::FUNC_SPLAT, -16'sd6144, 16'd1000, 8'd0);
        send_beat(sssn_pkg::FUNC_SPLAT, 16'd6000, 16'd2000, 8'd0);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd1);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd96);
        send_beat(sssn_pkg::FUNC_MIN, 16'd0, 16'd0, 8'd0);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd96);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd190);
        send_beat(sssn_pkg::FUNC_CLEAR, 16'd0, 16'd0, 8'd0);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd96);
        send_beat(sssn_pkg::FUNC_SPLAT, 16'h8000, 16'hFFFF, 8'd0);
        send_beat(sssn_pkg::FUNC_READ, 16'd0, 16'd0, 8'd64);
        settle();

        for (int ph = 0; ph < 6; ph++) begin
            reg_write(sssn_pkg::REG_EDGE, edge_set[ph]);
            reg_write(sssn_pkg::REG_FULL, full_set[ph]);
            send_quiet = (ph % 3 == 1);
            for (int k = 0; k < 255; k++) random_beat();
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
